[rtl/mws_pkg.sv]
// Shared constants and types for the moving window sum unit.
`timescale 1ns / 1ps
package mws_pkg;

  localparam int MAX_WINDOW  = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int WLEN_W      = 13;
  localparam int DIV_W       = 16;
  localparam int CFG_W       = 16;
  localparam int REG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIVISOR       = 1'd1;

  localparam logic [WLEN_W-1:0] WLEN_RESET    = 13'd4096;
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = 16'd4096;

  // Window control from the register block to the front end
  typedef struct packed {
    logic             clear;
    logic [LEN_W-1:0] len;
  } mws_ctl_t;

  // Running sum entering the queue
  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] sum;
  } mws_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mws_qstat_t;

endpackage

[rtl/mws_if.sv]
// Request channel interfaces for samples and results.
`timescale 1ns / 1ps
interface mws_in_if;
  import mws_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface mws_out_if;
  import mws_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SUM_W-1:0]       running_sum;
  logic signed [SAMPLE_BITS-1:0] scaled_sum;

  modport source (output valid, output running_sum, output scaled_sum, input ready);
  modport sink (input valid, input running_sum, input scaled_sum, output ready);
endinterface

[rtl/moving_window_sum_unit.sv]
// Top level of the moving window sum unit: registers, front end, queue, divider.
// The divider retires one quotient bit per cycle over the 36-bit sum and takes a new
// sum only when idle; the front end takes no new sample while it updates the last one,
// and a 4-entry queue absorbs short bursts.
// Reset (synchronous): window_length and divisor return to 4096 and the window is
// empty at once; a fill count masks unwritten ring slots, so there is no clearing pass.
`timescale 1ns / 1ps
module moving_window_sum_unit (
  input  logic                              clk,
  input  logic                              rst,
  mws_in_if.sink                            samples,
  mws_out_if.source                         results,
  input  logic                              cfg_we,
  input  logic [mws_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [mws_pkg::CFG_W-1:0]         cfg_data
);
  import mws_pkg::*;

  logic [WLEN_W-1:0] window_length;
  logic [DIV_W-1:0]  divisor;

  mws_ctl_t                ctl;
  mws_push_t               push;
  mws_qstat_t              qstat;
  logic                    pop;
  logic signed [SUM_W-1:0] head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      divisor       <= DIVISOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_W-1:0];
        REG_DIVISOR:       divisor <= cfg_data[DIV_W-1:0];
        default:           ;
      endcase
    end
  end

  // Zero length acts as one; anything past the store depth is clamped
  always_comb begin
    if (window_length == '0) begin
      ctl.len = LEN_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      ctl.len = LEN_W'(MAX_WINDOW);
    end else begin
      ctl.len = LEN_W'(window_length);
    end
    ctl.clear = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
  end

  mws_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .ctl     (ctl),
    .qstat   (qstat),
    .push    (push)
  );

  mws_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .stat (qstat),
    .head (head)
  );

  mws_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .head    (head),
    .divisor (divisor),
    .pop     (pop),
    .results (results)
  );

endmodule

[rtl/mws_front.sv]
// Front end: accepts samples, updates the ring store and the running sum.
`timescale 1ns / 1ps
module mws_front (
  input  logic                clk,
  input  logic                rst,
  mws_in_if.sink              samples,
  input  mws_pkg::mws_ctl_t   ctl,
  input  mws_pkg::mws_qstat_t qstat,
  output mws_pkg::mws_push_t  push
);
  import mws_pkg::*;

  localparam logic F_IDLE   = 1'b0;
  localparam logic F_UPDATE = 1'b1;

  logic                          fstate;
  logic [ADDR_W-1:0]             pos;
  logic [LEN_W-1:0]              fill;
  logic signed [SUM_W-1:0]       total;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];

  logic                          acc;
  logic [ADDR_W-1:0]             rd_addr;
  logic signed [SAMPLE_BITS-1:0] old;
  logic signed [SUM_W-1:0]       total_next;
  logic [LEN_W-1:0]              pos_inc;
  logic [ADDR_W-1:0]             pos_next;
  logic [LEN_W-1:0]              fill_next;

  assign samples.ready = (fstate == F_IDLE) && !qstat.full;
  assign acc = samples.valid && samples.ready;
  assign rd_addr = samples.restart ? '0 : pos;

  // Slots not written since the last clear read as zero
  assign old = ({1'b0, pos} < fill) ? rdata : '0;
  assign total_next = total - {{ADDR_W{old[SAMPLE_BITS-1]}}, old}
                      + {{ADDR_W{smp[SAMPLE_BITS-1]}}, smp};

  assign pos_inc   = {1'b0, pos} + LEN_W'(1);
  assign pos_next  = (pos_inc >= ctl.len) ? '0 : pos_inc[ADDR_W-1:0];
  assign fill_next = (fill < ctl.len) ? fill + LEN_W'(1) : fill;

  assign push.valid = (fstate == F_UPDATE);
  assign push.sum   = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      pos    <= '0;
      fill   <= '0;
      total  <= '0;
    end else if (ctl.clear) begin
      pos   <= '0;
      fill  <= '0;
      total <= '0;
    end else begin
      case (fstate)
        F_IDLE: begin
          if (acc) begin
            fstate <= F_UPDATE;
            if (samples.restart) begin
              pos   <= '0;
              fill  <= '0;
              total <= '0;
            end
          end
        end
        F_UPDATE: begin
          fstate <= F_IDLE;
          total  <= total_next;
          pos    <= pos_next;
          fill   <= fill_next;
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      smp   <= samples.sample;
      rdata <= mem[rd_addr];
    end
    if (fstate == F_UPDATE) begin
      mem[pos] <= smp;
    end
  end

  assert property (@(posedge clk) disable iff (rst) {1'b0, pos} < ctl.len)
    else $error("write position outside window");
  assert property (@(posedge clk) disable iff (rst) fill <= ctl.len)
    else $error("fill count beyond window length");
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !qstat.full)
    else $error("push into full queue");

endmodule

[rtl/mws_queue.sv]
// Small queue of running sums between the front end and the divider.
`timescale 1ns / 1ps
module mws_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  mws_pkg::mws_push_t            push,
  input  logic                          pop,
  output mws_pkg::mws_qstat_t           stat,
  output logic signed [mws_pkg::SUM_W-1:0] head
);
  import mws_pkg::*;

  logic signed [SUM_W-1:0] entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.sum;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

[rtl/mws_back.sv]
// Back end: bit-serial divide of the running sum, saturate, output register.
`timescale 1ns / 1ps
module mws_back (
  input  logic                             clk,
  input  logic                             rst,
  input  mws_pkg::mws_qstat_t              qstat,
  input  logic signed [mws_pkg::SUM_W-1:0] head,
  input  logic [mws_pkg::DIV_W-1:0]        divisor,
  output logic                             pop,
  mws_out_if.source                        results
);
  import mws_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  localparam logic [SUM_W-1:0] MAG_LIM =
    {{(SUM_W - SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic [1:0]                    bstate;
  logic [CNT_W-1:0]              cnt;
  logic signed [SUM_W-1:0]       sum_hold;
  logic                          neg;
  logic [DIV_W-1:0]              rem;
  logic [SUM_W-1:0]              quo;
  logic                          out_valid;
  logic signed [SUM_W-1:0]       out_sum;
  logic signed [SAMPLE_BITS-1:0] out_scaled;

  logic [DIV_W-1:0]       div_eff;
  logic [DIV_W:0]         shifted;
  logic [DIV_W:0]         diff;
  logic                   ge;
  logic [SUM_W-1:0]       qneg;
  logic [SAMPLE_BITS-1:0] scaled;
  logic                   load;

  assign div_eff = (divisor == '0) ? DIV_W'(1) : divisor;
  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, div_eff};
  assign ge      = (shifted >= {1'b0, div_eff});

  // Quotient magnitude truncates toward zero; restore sign, then clamp
  assign qneg   = -quo;
  assign scaled = neg ? ((quo > MAG_LIM) ? SAT_MIN : qneg[SAMPLE_BITS-1:0])
                      : ((quo >= MAG_LIM) ? SAT_MAX : quo[SAMPLE_BITS-1:0]);

  assign pop  = (bstate == B_IDLE) && !qstat.empty;
  assign load = (bstate == B_DONE) && (!out_valid || results.ready);

  assign results.valid       = out_valid;
  assign results.running_sum = out_sum;
  assign results.scaled_sum  = out_scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (bstate)
        B_IDLE: begin
          if (pop) begin
            bstate <= B_DIV;
            cnt    <= '0;
          end
        end
        B_DIV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(SUM_W - 1)) begin
            bstate <= B_DONE;
          end
        end
        B_DONE: begin
          if (load) begin
            bstate <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sum_hold <= head;
      neg      <= head[SUM_W-1];
      rem      <= '0;
      quo      <= head[SUM_W-1] ? -head : head;
    end else if (bstate == B_DIV) begin
      rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
    if (load) begin
      out_sum    <= sum_hold;
      out_scaled <= scaled;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
                   (bstate == B_DIV) |-> (cnt <= CNT_W'(SUM_W - 1)))
    else $error("divide step count overrun");

endmodule
